@@ rtl/dv_audio_sample_placement_top_assert.svh @@
// Assertion macros shared by the sample placement RTL.
`ifndef DV_AUDIO_SAMPLE_PLACEMENT_TOP_ASSERT_SVH
`define DV_AUDIO_SAMPLE_PLACEMENT_TOP_ASSERT_SVH

// Checked on every rising edge of clk outside reset.
`define SP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define SP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/dvasp_pkg.sv @@
// Types, constants and shuffle tables for the DV audio sample placement block.
`timescale 1ns / 1ps

package dvasp_pkg;

  localparam int unsigned IDX_W = 11;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned REM_W = 6;
  localparam int unsigned OFF_W = 18;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned PROD_W = 2 * IDX_W;

  localparam logic [SLOT_W-1:0] DIV_625 = 6'd54;
  localparam logic [SLOT_W-1:0] DIV_525 = 6'd45;
  // ceil(2^16 / divisor): exact quotient for every 11-bit index
  localparam logic [IDX_W-1:0] RECIP_625 = 11'd1214;
  localparam logic [IDX_W-1:0] RECIP_525 = 11'd1457;

  localparam logic [SLOT_W-1:0] SLOTS_PER_BLOCK = 6'd36;

  localparam logic [OFF_W-1:0] SEQ_BYTES = 18'(150 * 80);
  localparam logic [OFF_W-1:0] AUDIO_BASE = 18'(6 * 80);
  localparam logic [OFF_W-1:0] BLOCK_STRIDE = 18'(16 * 80);
  localparam logic [OFF_W-1:0] BLOCK_HDR = 18'd8;
  localparam logic [OFF_W-1:0] CH_OFFSET_625 = 18'(6 * 150 * 80);
  localparam logic [OFF_W-1:0] CH_OFFSET_525 = 18'(5 * 150 * 80);

  localparam logic [WORD_W-1:0] RESERVED_CODE = 16'h8000;
  localparam logic [WORD_W-1:0] SUBST_CODE = 16'h8001;

  localparam logic [REM_W-1:0] SHUF_625 [6][9] = '{
    '{ 6'd0,  6'd18, 6'd36, 6'd13, 6'd31, 6'd49, 6'd8,  6'd26, 6'd44 },
    '{ 6'd3,  6'd21, 6'd39, 6'd16, 6'd34, 6'd52, 6'd11, 6'd29, 6'd47 },
    '{ 6'd6,  6'd24, 6'd42, 6'd1,  6'd19, 6'd37, 6'd14, 6'd32, 6'd50 },
    '{ 6'd9,  6'd27, 6'd45, 6'd4,  6'd22, 6'd40, 6'd17, 6'd35, 6'd53 },
    '{ 6'd12, 6'd30, 6'd48, 6'd7,  6'd25, 6'd43, 6'd2,  6'd20, 6'd38 },
    '{ 6'd15, 6'd33, 6'd51, 6'd10, 6'd28, 6'd46, 6'd5,  6'd23, 6'd41 }
  };

  localparam logic [REM_W-1:0] SHUF_525 [5][9] = '{
    '{ 6'd0,  6'd15, 6'd30, 6'd10, 6'd25, 6'd40, 6'd5,  6'd20, 6'd35 },
    '{ 6'd3,  6'd18, 6'd33, 6'd13, 6'd28, 6'd43, 6'd8,  6'd23, 6'd38 },
    '{ 6'd6,  6'd21, 6'd36, 6'd1,  6'd16, 6'd31, 6'd11, 6'd26, 6'd41 },
    '{ 6'd9,  6'd24, 6'd39, 6'd4,  6'd19, 6'd34, 6'd14, 6'd29, 6'd44 },
    '{ 6'd12, 6'd27, 6'd42, 6'd7,  6'd22, 6'd37, 6'd2,  6'd17, 6'd32 }
  };

  // Sample after the quotient step, on its way to the result register
  typedef struct packed {
    logic              valid;
    logic              ch;
    logic              pal;
    logic [IDX_W-1:0]  idx;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] val;
  } slot_item_t;

  // Inverse shuffle: frame offset of the first audio byte for a remainder,
  // left channel. Works out to a constant table of 54 or 45 entries.
  function automatic logic [OFF_W-1:0] audio_base(input logic pal,
                                                  input logic [REM_W-1:0] rem);
    logic [2:0] seq;
    logic [3:0] blk;
    seq = '0;
    blk = '0;
    for (int s = 0; s < 6; s++) begin
      for (int b = 0; b < 9; b++) begin
        if (pal && SHUF_625[s][b] == rem) begin
          seq = 3'(s);
          blk = 4'(b);
        end
      end
    end
    for (int s = 0; s < 5; s++) begin
      for (int b = 0; b < 9; b++) begin
        if (!pal && SHUF_525[s][b] == rem) begin
          seq = 3'(s);
          blk = 4'(b);
        end
      end
    end
    return OFF_W'(seq) * SEQ_BYTES + AUDIO_BASE + OFF_W'(blk) * BLOCK_STRIDE + BLOCK_HDR;
  endfunction

endpackage

@@ rtl/dvasp_locate.sv @@
// Remainder, shuffle lookup, offset sum and reserved-code substitution feeding the result register.
`timescale 1ns / 1ps
`include "dv_audio_sample_placement_top_assert.svh"

module dvasp_locate import dvasp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  slot_item_t        item,
  output logic [OFF_W-1:0]  byte_offset,
  output logic [WORD_W-1:0] sample_word,
  output logic              placed
);

  logic [SLOT_W-1:0] divisor;
  logic [IDX_W-1:0]  q_times_d;
  logic [IDX_W-1:0]  rem_full;
  logic [REM_W-1:0]  rem;
  logic              in_range;
  logic [OFF_W-1:0]  ch_term;
  logic [OFF_W-1:0]  offset_next;
  logic [WORD_W-1:0] word_next;

  always_comb begin
    divisor   = item.pal ? DIV_625 : DIV_525;
    q_times_d = IDX_W'(item.slot) * IDX_W'(divisor);
    rem_full  = item.idx - q_times_d;
    rem       = rem_full[REM_W-1:0];
    in_range  = item.slot < SLOTS_PER_BLOCK;
    ch_term   = item.ch ? (item.pal ? CH_OFFSET_625 : CH_OFFSET_525) : '0;
    offset_next = '0;
    if (in_range) begin
      offset_next = audio_base(item.pal, rem) + ch_term + OFF_W'({item.slot, 1'b0});
    end
    word_next = (item.val == RESERVED_CODE) ? SUBST_CODE : item.val;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_offset <= offset_next;
      sample_word <= word_next;
      placed      <= in_range;
    end
  end

  `SP_ASSERT(a_quotient_exact, item.valid |-> (q_times_d <= item.idx) && (rem_full < IDX_W'(divisor)), "quotient step gave a wrong slot")
  `SP_ASSERT(a_reserved_gone, load |=> sample_word != RESERVED_CODE, "reserved code reached the result")
  `SP_ASSERT(a_drop_zero, load && !in_range |=> !placed && byte_offset == '0, "dropped sample has an offset")

endmodule

@@ rtl/dv_audio_sample_placement_top.sv @@
// Top level of the DV audio sample placement block.
//
//   channel  | valid     | stall     | payload
//   ---------+-----------+-----------+------------------------------------------
//   input    | in_valid  | in_stall  | channel, sample_index, sample_value
//   result   | out_valid | out_stall | byte_offset, sample_word, placed
//   config   | cfg_write | -         | cfg_data (pal_mode, bit 0)
//
// One transaction per cycle sustained while the result side does not stall; a result
// passes through the input register, quotient register and result register before it
// is on the outputs.
// The slot comes from one 11x11 reciprocal multiply; the remainder needs a small
// slot-by-divisor product in the next stage.
// rst is synchronous: it empties all three stages and sets pal_mode to 1.
// A stall on the result side fills the stages; in_stall rises only when all are full.
`timescale 1ns / 1ps
`include "dv_audio_sample_placement_top_assert.svh"

module dv_audio_sample_placement_top import dvasp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              channel,
  input  logic [IDX_W-1:0]  sample_index,
  input  logic [WORD_W-1:0] sample_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OFF_W-1:0]  byte_offset,
  output logic [WORD_W-1:0] sample_word,
  output logic              placed,
  input  logic              cfg_write,
  input  logic              cfg_data
);

  logic              pal_mode;
  logic              s0_valid;
  logic              s0_ch;
  logic              s0_pal;
  logic [IDX_W-1:0]  s0_idx;
  logic [WORD_W-1:0] s0_val;
  slot_item_t        s1;
  logic [PROD_W-1:0] recip_prod;
  logic              ready_out;
  logic              ready1;
  logic              ready0;

  always_comb begin
    ready_out  = !out_valid || !out_stall;
    ready1     = !s1.valid || ready_out;
    ready0     = !s0_valid || ready1;
    in_stall   = !ready0;
    recip_prod = PROD_W'(s0_idx) * PROD_W'(s0_pal ? RECIP_625 : RECIP_525);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_mode <= 1'b1;
    end else if (cfg_write) begin
      pal_mode <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (ready0) begin
      s0_valid <= in_valid;
    end
    if (ready0 && in_valid) begin
      s0_ch  <= channel;
      s0_pal <= pal_mode;
      s0_idx <= sample_index;
      s0_val <= sample_value;
    end
  end

  // Quotient register: slot = index / divisor by reciprocal
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (ready1) begin
      s1.valid <= s0_valid;
    end
    if (ready1 && s0_valid) begin
      s1.ch   <= s0_ch;
      s1.pal  <= s0_pal;
      s1.idx  <= s0_idx;
      s1.slot <= recip_prod[RECIP_SHIFT +: SLOT_W];
      s1.val  <= s0_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_out) begin
      out_valid <= s1.valid;
    end
  end

  dvasp_locate u_locate (
    .clk         (clk),
    .rst         (rst),
    .load        (ready_out && s1.valid),
    .item        (s1),
    .byte_offset (byte_offset),
    .sample_word (sample_word),
    .placed      (placed)
  );

  `SP_ASSERT(a_stall_only_full, in_stall |-> s0_valid && s1.valid && out_valid, "input held while a stage is empty")
  `SP_ASSERT_ALWAYS(a_reset_empties, rst |=> !out_valid && !s0_valid && !s1.valid, "stage valid after reset")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the DV audio sample placement block.
`timescale 1ns / 1ps

module tb_top;
  import dvasp_pkg::*;

  localparam bit MODE_525 = 1'b0;
  localparam bit MODE_625 = 1'b1;

  localparam int DIF_SEQ_BYTES = 150 * 80;
  localparam int AUDIO_START = 6 * 80;
  localparam int AUDIO_BLOCK_PITCH = 16 * 80;
  localparam int AUDIO_HDR = 8;
  localparam int SLOT_LIMIT = 36;
  localparam int LAST_IDX_625 = 36 * 54 - 1;
  localparam int LAST_IDX_525 = 36 * 45 - 1;
  localparam logic [WORD_W-1:0] CODE_RESERVED = 16'h8000;
  localparam logic [WORD_W-1:0] CODE_STAND_IN = 16'h8001;
  localparam int DRAIN_CYCLES = 6;
  localparam int IDLE_PCT = 12;
  localparam int REPORT_LIMIT = 10;

  localparam int SHUF_50 [6][9] = '{
    '{  0, 18, 36, 13, 31, 49,  8, 26, 44 },
    '{  3, 21, 39, 16, 34, 52, 11, 29, 47 },
    '{  6, 24, 42,  1, 19, 37, 14, 32, 50 },
    '{  9, 27, 45,  4, 22, 40, 17, 35, 53 },
    '{ 12, 30, 48,  7, 25, 43,  2, 20, 38 },
    '{ 15, 33, 51, 10, 28, 46,  5, 23, 41 }
  };

  localparam int SHUF_60 [5][9] = '{
    '{  0, 15, 30, 10, 25, 40,  5, 20, 35 },
    '{  3, 18, 33, 13, 28, 43,  8, 23, 38 },
    '{  6, 21, 36,  1, 16, 31, 11, 26, 41 },
    '{  9, 24, 39,  4, 19, 34, 14, 29, 44 },
    '{ 12, 27, 42,  7, 22, 37,  2, 17, 32 }
  };

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [WORD_W-1:0] word;
    logic              placed;
  } placement_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              channel;
  logic [IDX_W-1:0]  sample_index;
  logic [WORD_W-1:0] sample_value;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [OFF_W-1:0]  byte_offset;
  logic [WORD_W-1:0] sample_word;
  logic              placed;
  logic              cfg_write;
  logic              cfg_data;

  placement_t placement_q[$];
  bit         frame_mode;
  bit         quiet;
  int         mismatches;
  int         samples_sent;
  int         samples_dropped;
  int         reserved_seen;
  int         mode_writes;

  dv_audio_sample_placement_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .channel      (channel),
    .sample_index (sample_index),
    .sample_value (sample_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_offset  (byte_offset),
    .sample_word  (sample_word),
    .placed       (placed),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic placement_t predict_placement(bit mode, bit ch,
                                                   logic [IDX_W-1:0] idx,
                                                   logic [WORD_W-1:0] val);
    placement_t p;
    int divisor;
    int half;
    int slot;
    int rem;
    int seq;
    int blk;
    divisor = (mode == MODE_625) ? 54 : 45;
    half = (mode == MODE_625) ? 6 : 5;
    slot = int'(idx) / divisor;
    rem = int'(idx) % divisor;
    seq = 0;
    blk = 0;
    p.word = (val == CODE_RESERVED) ? CODE_STAND_IN : val;
    p.offset = '0;
    p.placed = 1'b0;
    if (slot < SLOT_LIMIT) begin
      // invert the shuffle: find the sequence and block holding this remainder
      for (int s = 0; s < 6; s++) begin
        for (int b = 0; b < 9; b++) begin
          if (mode == MODE_625 && SHUF_50[s][b] == rem) begin
            seq = s;
            blk = b;
          end
          if (mode == MODE_525 && s < 5 && SHUF_60[s % 5][b] == rem) begin
            seq = s;
            blk = b;
          end
        end
      end
      seq = seq + (ch ? half : 0);
      p.offset = OFF_W'(seq * DIF_SEQ_BYTES + AUDIO_START + blk * AUDIO_BLOCK_PITCH
                        + AUDIO_HDR + 2 * slot);
      p.placed = 1'b1;
    end
    return p;
  endfunction

  task automatic send_sample(bit ch, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] val);
    placement_t p;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    channel <= ch;
    sample_index <= idx;
    sample_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_placement(frame_mode, ch, idx, val);
    placement_q.push_back(p);
    samples_sent++;
    if (!p.placed) samples_dropped++;
    if (val == CODE_RESERVED) reserved_seen++;
  endtask

  task automatic send_random_sample();
    int limit;
    int pick;
    logic [IDX_W-1:0] idx;
    logic [WORD_W-1:0] val;
    limit = (frame_mode == MODE_625) ? LAST_IDX_625 : LAST_IDX_525;
    // mostly indices inside the layout, the rest anywhere in the field
    if ($urandom_range(99) < 85) idx = IDX_W'($urandom_range(limit));
    else idx = IDX_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 5) val = CODE_RESERVED;
    else if (pick < 8) val = CODE_STAND_IN;
    else if (pick < 10) val = (pick == 8) ? 16'hFFFF : 16'h7FFF;
    else val = WORD_W'($urandom);
    send_sample(1'($urandom), idx, val);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_frame_mode(bit mode);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= mode;
    @(negedge clk);
    cfg_write <= 1'b0;
    frame_mode = mode;
    mode_writes++;
  endtask

  // reset value of the mode register is 625/50
  task automatic test_reset_mode();
    send_sample(1'b0, 11'd0, 16'h0000);
    send_sample(1'b1, IDX_W'(LAST_IDX_625), 16'hFFFF);
    send_sample(1'b0, IDX_W'(LAST_IDX_625 + 1), CODE_RESERVED);
    send_sample(1'b1, 11'd2047, 16'h7FFF);
    send_sample(1'b0, 11'd53, CODE_STAND_IN);
    send_sample(1'b1, 11'd54, CODE_RESERVED);
    send_sample(1'b0, 11'd24, 16'h1234);
    send_sample(1'b0, 11'd25, 16'h00FF);
    send_sample(1'b1, 11'd1889, 16'hFF00);
    send_sample(1'b0, 11'd1000, 16'h5A5A);
  endtask

  task automatic test_525_directed();
    set_frame_mode(MODE_525);
    send_sample(1'b0, 11'd0, CODE_RESERVED);
    send_sample(1'b1, 11'd44, 16'h0000);
    send_sample(1'b0, 11'd45, 16'hFFFF);
    send_sample(1'b1, IDX_W'(LAST_IDX_525), 16'h7FFF);
    send_sample(1'b0, IDX_W'(LAST_IDX_525 + 1), CODE_RESERVED);
    send_sample(1'b1, 11'd2047, 16'h0001);
    send_sample(1'b1, IDX_W'(LAST_IDX_625), CODE_STAND_IN);
    send_sample(1'b0, 11'd900, 16'hA5A5);
  endtask

  task automatic test_random_modes();
    for (int phase = 0; phase < 4; phase++) begin
      set_frame_mode(phase[0] ? MODE_525 : MODE_625);
      repeat (380) send_random_sample();
    end
  endtask

  task automatic test_back_to_back();
    set_frame_mode(MODE_625);
    quiet = 1'b1;
    repeat (200) send_random_sample();
    set_frame_mode(MODE_525);
    repeat (100) send_random_sample();
    quiet = 1'b0;
  endtask

  task automatic test_drain_pause();
    set_frame_mode(MODE_625);
    for (int burst = 0; burst < 4; burst++) begin
      repeat (12) send_random_sample();
      // hold the sender until every result has come back
      wait_drained();
    end
  endtask

  always @(negedge clk) begin
    out_stall <= !rst && !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin : check_result
    placement_t want;
    if (!rst && out_valid && !out_stall) begin
      if (placement_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected transaction: offset %0d word %h placed %b",
                   byte_offset, sample_word, placed);
      end else begin
        want = placement_q.pop_front();
        if (byte_offset !== want.offset || sample_word !== want.word
            || placed !== want.placed) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch: offset %0d/%0d word %h/%h placed %b/%b (expected/actual)",
                     want.offset, byte_offset, want.word, sample_word,
                     want.placed, placed);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int guard;
    rst = 1'b1;
    in_valid = 1'b0;
    channel = 1'b0;
    sample_index = '0;
    sample_value = '0;
    cfg_write = 1'b0;
    cfg_data = 1'b0;
    quiet = 1'b0;
    frame_mode = MODE_625;
    mismatches = 0;
    samples_sent = 0;
    samples_dropped = 0;
    reserved_seen = 0;
    mode_writes = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_mode();
    test_525_directed();
    test_random_modes();
    test_back_to_back();
    test_drain_pause();

    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (placement_q.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (placement_q.size() != 0) begin
      $display("%0d results never arrived", placement_q.size());
      mismatches += placement_q.size();
    end
    $display("Placed %0d samples in both frame modes (%0d beyond the layout, %0d reserved codes)",
             samples_sent, samples_dropped, reserved_seen);
    $display("with %0d mode register writes and random stalls on both sides.", mode_writes);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
